/* rtl/cabct_pkg.sv */
// shared constants and types for the circle and box collision test
package cabct_pkg;

   localparam int COORD_BITS_DEFAULT = 24;
   localparam int MODE_BITS          = 2;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_CIRCLE_CIRCLE = 2'd0,
      MODE_CIRCLE_BOX    = 2'd1,
      MODE_BOX_BOX       = 2'd2,
      MODE_UNUSED        = 2'd3
   } mode_type;

   typedef struct packed {
      logic force_hit;
      logic use_cmp;
   } flags_type;

endpackage

/* rtl/cabct_prep.sv */
// first stage: per-mode differences, nearest box point and decided flags
module cabct_prep #(
   parameter int COORD_BITS = cabct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [cabct_pkg::MODE_BITS-1:0]     mode,
   input  logic signed [COORD_BITS-1:0]        a_x_lo,
   input  logic signed [COORD_BITS-1:0]        a_y_lo,
   input  logic signed [COORD_BITS-1:0]        a_x_hi_or_radius,
   input  logic signed [COORD_BITS-1:0]        a_y_hi,
   input  logic signed [COORD_BITS-1:0]        b_x_lo,
   input  logic signed [COORD_BITS-1:0]        b_y_lo,
   input  logic signed [COORD_BITS-1:0]        b_x_hi_or_radius,
   input  logic signed [COORD_BITS-1:0]        b_y_hi,
   output logic signed [COORD_BITS:0]          dx_ff,
   output logic signed [COORD_BITS:0]          dy_ff,
   output logic signed [COORD_BITS:0]          r_ff,
   output cabct_pkg::flags_type                flags_ff
);

   logic signed [COORD_BITS:0] ax0, ay0, ax1, bx0, by0, bx1, by1;
   logic signed [COORD_BITS:0] dx_in, dy_in, r_in;
   cabct_pkg::flags_type       flags_in;
   logic below_x, above_x, below_y, above_y, in_box, box_hit;

   assign ax0 = {a_x_lo[COORD_BITS-1], a_x_lo};
   assign ay0 = {a_y_lo[COORD_BITS-1], a_y_lo};
   assign ax1 = {a_x_hi_or_radius[COORD_BITS-1], a_x_hi_or_radius};
   assign bx0 = {b_x_lo[COORD_BITS-1], b_x_lo};
   assign by0 = {b_y_lo[COORD_BITS-1], b_y_lo};
   assign bx1 = {b_x_hi_or_radius[COORD_BITS-1], b_x_hi_or_radius};
   assign by1 = {b_y_hi[COORD_BITS-1], b_y_hi};

   assign below_x = a_x_lo < b_x_lo;
   assign above_x = a_x_lo > b_x_hi_or_radius;
   assign below_y = a_y_lo < b_y_lo;
   assign above_y = a_y_lo > b_y_hi;
   assign in_box  = !(below_x || above_x || below_y || above_y);
   assign box_hit = !(a_x_hi_or_radius < b_x_lo || a_x_lo > b_x_hi_or_radius ||
                      a_y_hi < b_y_lo || a_y_lo > b_y_hi);

   always_comb begin
      dx_in    = '0;
      dy_in    = '0;
      r_in     = '0;
      flags_in = '0;
      unique case (cabct_pkg::mode_type'(mode))
         cabct_pkg::MODE_CIRCLE_CIRCLE: begin
            dx_in            = ax0 - bx0;
            dy_in            = ay0 - by0;
            r_in             = ax1 + bx1;
            flags_in.use_cmp = 1'b1;
         end
         cabct_pkg::MODE_CIRCLE_BOX: begin
            // clamp of the centre to the box, min tested first
            if (below_x) begin
               dx_in = ax0 - bx0;
            end else if (above_x) begin
               dx_in = ax0 - bx1;
            end
            if (below_y) begin
               dy_in = ay0 - by0;
            end else if (above_y) begin
               dy_in = ay0 - by1;
            end
            r_in               = ax1;
            flags_in.use_cmp   = 1'b1;
            flags_in.force_hit = in_box;
         end
         cabct_pkg::MODE_BOX_BOX: begin
            flags_in.force_hit = box_hit;
         end
         default: begin
            flags_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         r_ff     <= r_in;
         flags_ff <= flags_in;
      end
   end

endmodule

/* rtl/cabct_square.sv */
// second and third stages: magnitudes, then exact squares
module cabct_square #(
   parameter int COORD_BITS = cabct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          enable_mag,
   input  logic                          enable_sq,
   input  logic signed [COORD_BITS:0]    dx,
   input  logic signed [COORD_BITS:0]    dy,
   input  logic signed [COORD_BITS:0]    r,
   input  cabct_pkg::flags_type          flags,
   output logic [2*COORD_BITS+1:0]       sq_x_ff,
   output logic [2*COORD_BITS+1:0]       sq_y_ff,
   output logic [2*COORD_BITS+1:0]       sq_r_ff,
   output cabct_pkg::flags_type          flags_ff
);

   localparam int MAG_W = COORD_BITS + 1;
   localparam int SQ_W  = 2 * MAG_W;

   logic [MAG_W-1:0]     mag_x_in, mag_y_in, mag_r_in;
   logic [MAG_W-1:0]     mag_x_ff, mag_y_ff, mag_r_ff;
   cabct_pkg::flags_type mag_flags_ff;
   logic [SQ_W-1:0]      sq_x_in, sq_y_in, sq_r_in;

   assign mag_x_in = dx[COORD_BITS] ? (~dx) + 1'b1 : dx;
   assign mag_y_in = dy[COORD_BITS] ? (~dy) + 1'b1 : dy;
   assign mag_r_in = r[COORD_BITS]  ? (~r) + 1'b1  : r;

   assign sq_x_in = {{MAG_W{1'b0}}, mag_x_ff} * {{MAG_W{1'b0}}, mag_x_ff};
   assign sq_y_in = {{MAG_W{1'b0}}, mag_y_ff} * {{MAG_W{1'b0}}, mag_y_ff};
   assign sq_r_in = {{MAG_W{1'b0}}, mag_r_ff} * {{MAG_W{1'b0}}, mag_r_ff};

   always_ff @(posedge clock) begin
      if (enable_mag) begin
         mag_x_ff     <= mag_x_in;
         mag_y_ff     <= mag_y_in;
         mag_r_ff     <= mag_r_in;
         mag_flags_ff <= flags;
      end
      if (enable_sq) begin
         sq_x_ff  <= sq_x_in;
         sq_y_ff  <= sq_y_in;
         sq_r_ff  <= sq_r_in;
         flags_ff <= mag_flags_ff;
      end
   end

endmodule

/* rtl/cabct_cmp.sv */
// last stage: distance sum against squared radius, result register
module cabct_cmp #(
   parameter int COORD_BITS = cabct_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [2*COORD_BITS+1:0]       sq_x,
   input  logic [2*COORD_BITS+1:0]       sq_y,
   input  logic [2*COORD_BITS+1:0]       sq_r,
   input  cabct_pkg::flags_type          flags,
   output logic                          overlap_ff
);

   localparam int SUM_W = 2 * COORD_BITS + 3;

   logic [SUM_W-1:0] dist_sum;
   logic             closer;
   logic             overlap_in;

   assign dist_sum   = {1'b0, sq_x} + {1'b0, sq_y};
   assign closer     = dist_sum < {1'b0, sq_r};
   assign overlap_in = flags.force_hit || (flags.use_cmp && closer);

   always_ff @(posedge clock) begin
      if (enable) begin
         overlap_ff <= overlap_in;
      end
   end

endmodule

/* rtl/circle_and_box_collision_test.sv */
// top level of the circle and box collision test pipeline
// throughput: one item per cycle while rsp_tready is not held low, set by the four
//   register stages (prep, magnitude, square, compare) each taking one item a cycle
// a stalled result holds in the last stage while earlier stages keep filling
// reset clears only the stage valid bits; data registers are not reset
module circle_and_box_collision_test #(
   parameter int COORD_BITS = cabct_pkg::COORD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // mode, a_x_lo, a_y_lo, a_x_hi_or_radius, a_y_hi,
   // b_x_lo, b_y_lo, b_x_hi_or_radius, b_y_hi, zero pad
   input  logic [((cabct_pkg::MODE_BITS+8*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // overlap, zero pad
   output logic [7:0] rsp_tdata
);

   localparam int MB = cabct_pkg::MODE_BITS;

   logic en1, en2, en3, en4;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [COORD_BITS-1:0] a_x_lo, a_y_lo, a_x_hi_or_radius, a_y_hi;
   logic signed [COORD_BITS-1:0] b_x_lo, b_y_lo, b_x_hi_or_radius, b_y_hi;

   logic signed [COORD_BITS:0] dx_ff, dy_ff, r_ff;
   cabct_pkg::flags_type       prep_flags_ff, sq_flags_ff;
   logic [2*COORD_BITS+1:0]    sq_x_ff, sq_y_ff, sq_r_ff;
   logic                       overlap_ff;

   assign a_x_lo           = req_tdata[MB+0*COORD_BITS +: COORD_BITS];
   assign a_y_lo           = req_tdata[MB+1*COORD_BITS +: COORD_BITS];
   assign a_x_hi_or_radius = req_tdata[MB+2*COORD_BITS +: COORD_BITS];
   assign a_y_hi           = req_tdata[MB+3*COORD_BITS +: COORD_BITS];
   assign b_x_lo           = req_tdata[MB+4*COORD_BITS +: COORD_BITS];
   assign b_y_lo           = req_tdata[MB+5*COORD_BITS +: COORD_BITS];
   assign b_x_hi_or_radius = req_tdata[MB+6*COORD_BITS +: COORD_BITS];
   assign b_y_hi           = req_tdata[MB+7*COORD_BITS +: COORD_BITS];

   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_tready = en1;
   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {7'd0, overlap_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_tvalid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   cabct_prep #(.COORD_BITS(COORD_BITS)) u_prep (
      .clock            (clock),
      .enable           (en1),
      .mode             (req_tdata[MB-1:0]),
      .a_x_lo           (a_x_lo),
      .a_y_lo           (a_y_lo),
      .a_x_hi_or_radius (a_x_hi_or_radius),
      .a_y_hi           (a_y_hi),
      .b_x_lo           (b_x_lo),
      .b_y_lo           (b_y_lo),
      .b_x_hi_or_radius (b_x_hi_or_radius),
      .b_y_hi           (b_y_hi),
      .dx_ff            (dx_ff),
      .dy_ff            (dy_ff),
      .r_ff             (r_ff),
      .flags_ff         (prep_flags_ff)
   );

   cabct_square #(.COORD_BITS(COORD_BITS)) u_square (
      .clock      (clock),
      .enable_mag (en2),
      .enable_sq  (en3),
      .dx         (dx_ff),
      .dy         (dy_ff),
      .r          (r_ff),
      .flags      (prep_flags_ff),
      .sq_x_ff    (sq_x_ff),
      .sq_y_ff    (sq_y_ff),
      .sq_r_ff    (sq_r_ff),
      .flags_ff   (sq_flags_ff)
   );

   cabct_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
      .clock      (clock),
      .enable     (en4),
      .sq_x       (sq_x_ff),
      .sq_y       (sq_y_ff),
      .sq_r       (sq_r_ff),
      .flags      (sq_flags_ff),
      .overlap_ff (overlap_ff)
   );

endmodule
